// ===== rtl/qwt_pkg.sv =====
// ----------------------------------------------------------------------------
// qwt_pkg: shared types and codes of the quoted word tokenizer
// Holds the line-state record, the result record and the kind/status codes.
// ----------------------------------------------------------------------------
package qwt_pkg;

  localparam int RES_MAX = 3;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_TOO_MANY  = 2'd1;
  localparam logic [1:0] STAT_QUOTE     = 2'd2;
  localparam logic [1:0] STAT_BACKSLASH = 2'd3;

  typedef struct packed {
    logic       in_word;
    logic       single_quoted;
    logic       double_quoted;
    logic       escape_pending;
    logic       greater_pending;
    logic [6:0] tokens_done;
    logic [1:0] error_code;
  } line_state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] token_byte;
    logic [6:0] token_count;
    logic [1:0] status;
  } result_t;

  typedef result_t [RES_MAX-1:0] result_vec_t;

endpackage

// ===== rtl/qwt_step.sv =====
// ----------------------------------------------------------------------------
// qwt_step: next-state and result logic for one request
// Decides, for one line byte or end of line, the new line state and up to
// three results in order.
// ----------------------------------------------------------------------------
module qwt_step (
  input  qwt_pkg::line_state_t st,
  input  logic                 mode,
  input  logic [7:0]           c,
  input  logic [6:0]           limit,
  output qwt_pkg::line_state_t st_nxt,
  output qwt_pkg::result_vec_t res,
  output logic [1:0]           res_cnt
);
  import qwt_pkg::*;

  localparam logic [7:0] CH_LT = 8'h3C;
  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_DQ = 8'h22;
  localparam logic [7:0] CH_SQ = 8'h27;
  localparam logic [7:0] CH_BS = 8'h5C;

  function automatic result_t mk(input logic [1:0] kind, input logic [7:0] b,
                                 input logic [6:0] cnt, input logic [1:0] status);
    result_t r;
    r.kind        = kind;
    r.token_byte  = b;
    r.token_count = cnt;
    r.status      = status;
    return r;
  endfunction

  logic       blank;
  logic       is_lt;
  logic       is_gt;
  logic       fin;
  logic       wb;
  logic       q_s;
  logic       q_d;
  logic       quoted;
  logic [6:0] cnt;
  logic [1:0] n;
  logic [1:0] status;

  assign blank = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  assign is_lt = (c == CH_LT);
  assign is_gt = (c == CH_GT);

  always_comb begin
    st_nxt = st;
    res    = '0;
    n      = 2'd0;
    cnt    = st.tokens_done;
    fin    = 1'b0;
    wb     = 1'b0;
    q_s    = st.single_quoted;
    q_d    = st.double_quoted;
    quoted = st.single_quoted | st.double_quoted;
    status = st.error_code;
    if (mode) begin
      if (status == STAT_OK) begin
        if (st.escape_pending) begin
          status = STAT_BACKSLASH;
        end else if (st.in_word && quoted) begin
          status = STAT_QUOTE;
        end else if (st.in_word || st.greater_pending) begin
          cnt    = cnt + 7'd1;
          res[n] = mk(KIND_END, 8'd0, cnt, STAT_OK);
          n      = n + 2'd1;
        end
      end
      res[n] = mk(KIND_DONE, 8'd0, cnt, status);
      n      = n + 2'd1;
      st_nxt = '0;
    end else if (st.error_code == STAT_OK) begin
      // close a pending '>' token, or grow it into '>>'
      if (st.greater_pending) begin
        st_nxt.greater_pending = 1'b0;
        if (is_gt) begin
          res[n] = mk(KIND_BYTE, c, cnt, STAT_OK);
          n      = n + 2'd1;
          fin    = 1'b1;
        end
        cnt    = cnt + 7'd1;
        res[n] = mk(KIND_END, 8'd0, cnt, STAT_OK);
        n      = n + 2'd1;
      end
      if (!fin && st.escape_pending) begin
        st_nxt.escape_pending = 1'b0;
        res[n] = mk(KIND_BYTE, c, cnt, STAT_OK);
        n      = n + 2'd1;
        fin    = 1'b1;
      end
      if (!fin && st.in_word) begin
        if (!quoted && (blank || is_lt || is_gt)) begin
          st_nxt.in_word = 1'b0;
          cnt    = cnt + 7'd1;
          res[n] = mk(KIND_END, 8'd0, cnt, STAT_OK);
          n      = n + 2'd1;
          fin    = blank;
        end else begin
          wb  = 1'b1;
          fin = 1'b1;
        end
      end
      if (!fin && !blank) begin
        if (cnt >= limit) begin
          st_nxt.error_code = STAT_TOO_MANY;
        end else if (is_lt) begin
          res[n] = mk(KIND_BYTE, c, cnt, STAT_OK);
          n      = n + 2'd1;
          cnt    = cnt + 7'd1;
          res[n] = mk(KIND_END, 8'd0, cnt, STAT_OK);
          n      = n + 2'd1;
        end else if (is_gt) begin
          st_nxt.greater_pending = 1'b1;
          res[n] = mk(KIND_BYTE, c, cnt, STAT_OK);
          n      = n + 2'd1;
        end else begin
          // open a word with both quote flags clear
          st_nxt.in_word       = 1'b1;
          st_nxt.single_quoted = 1'b0;
          st_nxt.double_quoted = 1'b0;
          q_s = 1'b0;
          q_d = 1'b0;
          wb  = 1'b1;
        end
      end
      if (wb) begin
        if (!q_s && c == CH_DQ) begin
          st_nxt.double_quoted = ~q_d;
        end else if (!q_d && c == CH_SQ) begin
          st_nxt.single_quoted = ~q_s;
        end else if (!q_s && c == CH_BS) begin
          st_nxt.escape_pending = 1'b1;
        end else begin
          res[n] = mk(KIND_BYTE, c, cnt, STAT_OK);
          n      = n + 2'd1;
        end
      end
      st_nxt.tokens_done = cnt;
    end
    res_cnt = n;
  end

endmodule

// ===== rtl/quoted_word_tokenizer.sv =====
// ----------------------------------------------------------------------------
// quoted_word_tokenizer: shell-style word splitter with quotes
// Splits a byte stream of command lines into tokens and line-done records.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one request per line byte (in_tuser = 0) or end of line
//            (in_tuser = 1); line byte in in_tdata.
//   out_*  : token bytes, token ends and one line-done record per line.
//            out_tuser is the kind, out_tlast marks the last result of a
//            request, out_tdata carries byte, token count and status.
//   cfg_*  : writes the token limit (7 bits); always ready, write while idle.
// Results are registered and appear in the cycle after a request is accepted.
// Throughput: one request per cycle while each makes at most one result and
//   out_tready is high; a request making more results holds the input until
//   its last is taken; the single output register drains one per ready cycle.
// Reset clears the line state and loads the limit with MAX_TOKENS (max 127).
// When the receiver stalls, results hold and the input stops once the
// last buffered result is not being taken.
// ----------------------------------------------------------------------------
module quoted_word_tokenizer #(
  parameter int MAX_TOKENS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] line_byte
  input  logic        in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] token_byte, [14:8] token_count,
                                  // [16:15] status, rest zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,  // run_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data    // [6:0] token_limit
);
  import qwt_pkg::*;

  localparam logic [6:0] LIMIT_RST = (MAX_TOKENS > 127) ? 7'd127 : 7'(MAX_TOKENS);

  line_state_t st_r, st_nxt;
  result_vec_t res_r, res_nxt;
  logic [1:0]  res_cnt;
  logic [1:0]  rem_r;
  logic [1:0]  idx_r;
  logic [6:0]  limit_r;
  logic [6:0]  limit_eff;
  logic        in_fire;
  logic        out_fire;
  result_t     cur;

  assign limit_eff = ({2'b00, limit_r} > 9'(MAX_TOKENS)) ? 7'(MAX_TOKENS) : limit_r;

  qwt_step u_step (
    .st      (st_r),
    .mode    (in_tuser),
    .c       (in_tdata),
    .limit   (limit_eff),
    .st_nxt  (st_nxt),
    .res     (res_nxt),
    .res_cnt (res_cnt)
  );

  assign cfg_ready  = 1'b1;
  assign in_tready  = (rem_r == 2'd0) || (rem_r == 2'd1 && out_tready);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = (rem_r != 2'd0);
  assign out_fire   = out_tvalid && out_tready;

  assign cur       = res_r[idx_r];
  assign out_tuser = cur.kind;
  assign out_tdata = {7'd0, cur.status, cur.token_count, cur.token_byte};
  assign out_tlast = (rem_r == 2'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= '0;
      rem_r   <= 2'd0;
      idx_r   <= 2'd0;
      limit_r <= LIMIT_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
      if (in_fire) begin
        st_r  <= st_nxt;
        rem_r <= res_cnt;
        idx_r <= 2'd0;
      end else if (out_fire) begin
        rem_r <= rem_r - 2'd1;
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  // result payload, loaded with each request
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_tlast && !in_fire) |=> !out_tvalid)
    else $error("output still valid after last result taken");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_DONE) |-> out_tlast)
    else $error("line-done is not the last result of its request");

  a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser) |=> (st_r == '0 && out_tvalid))
    else $error("end of line did not clear state or give a result");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

// ===== tb/sv/quoted_word_tokenizer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_word_tokenizer_test: self-checking bench for the word tokenizer
// Feeds command lines byte by byte with random bursts and output stalls,
// predicts token bytes, token ends and line-done records, and compares each
// result in order. The token limit is swept between lines.
// ----------------------------------------------------------------------------
module quoted_word_tokenizer_test;
  import qwt_pkg::*;

  localparam int TOKEN_CAP = 64;

  localparam bit MODE_BYTE = 1'b0;
  localparam bit MODE_EOL  = 1'b1;

  localparam logic [7:0] CH_LT    = "<";
  localparam logic [7:0] CH_GT    = ">";
  localparam logic [7:0] CH_DQ    = "\"";
  localparam logic [7:0] CH_SQ    = "'";
  localparam logic [7:0] CH_BSL   = "\\";
  localparam logic [7:0] CH_A     = "a";
  localparam logic [7:0] CH_X     = "x";
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] BLANKS [6] = '{8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};

  typedef struct {
    logic [1:0] kind;
    logic [7:0] tok;
    logic [6:0] count;
    logic [1:0] status;
    logic       last;
  } token_event_t;

  class token_scoreboard;
    bit         in_word, single_q, double_q, escape_open, greater_open;
    bit [6:0]   tokens_done;
    bit [1:0]   err_code;
    bit [6:0]   token_limit = 7'(TOKEN_CAP);
    token_event_t token_events[$];
    token_event_t step_events[$];
    int         mismatches;
    int         checked;
    int         lines_done;
    int         status_seen [4];

    task report(string what);
      mismatches++;
      if (mismatches <= 30) $display("%0t ns mismatch: %s", $time, what);
    endtask

    function int limit_now();
      return (int'(token_limit) > TOKEN_CAP) ? TOKEN_CAP : int'(token_limit);
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function void push(logic [1:0] kind, logic [7:0] b, logic [1:0] st);
      token_event_t ev;
      ev.kind   = kind;
      ev.tok    = b;
      ev.count  = tokens_done;
      ev.status = st;
      ev.last   = 1'b0;
      step_events.push_back(ev);
    endfunction

    function void close_token();
      tokens_done = tokens_done + 7'd1;
      push(KIND_END, 8'd0, STAT_OK);
    endfunction

    function void word_char(logic [7:0] c);
      if (!single_q && c == CH_DQ) double_q = !double_q;
      else if (!double_q && c == CH_SQ) single_q = !single_q;
      else if (!single_q && c == CH_BSL) escape_open = 1'b1;
      else push(KIND_BYTE, c, STAT_OK);
    endfunction

    function void take_line_byte(logic [7:0] c);
      bit quoted;
      if (greater_open) begin
        greater_open = 1'b0;
        // a second '>' joins the open redirection token
        if (c == CH_GT) begin
          push(KIND_BYTE, c, STAT_OK);
          close_token();
          return;
        end
        close_token();
      end
      if (escape_open) begin
        escape_open = 1'b0;
        push(KIND_BYTE, c, STAT_OK);
        return;
      end
      if (in_word) begin
        quoted = single_q || double_q;
        if (!quoted && is_blank(c)) begin
          in_word = 1'b0;
          close_token();
          return;
        end
        if (!quoted && (c == CH_LT || c == CH_GT)) begin
          in_word = 1'b0;
          close_token();
        end else begin
          word_char(c);
          return;
        end
      end
      if (is_blank(c)) return;
      if (int'(tokens_done) >= limit_now()) begin
        err_code = STAT_TOO_MANY;
        return;
      end
      if (c == CH_LT) begin
        push(KIND_BYTE, c, STAT_OK);
        close_token();
        return;
      end
      if (c == CH_GT) begin
        greater_open = 1'b1;
        push(KIND_BYTE, c, STAT_OK);
        return;
      end
      in_word  = 1'b1;
      single_q = 1'b0;
      double_q = 1'b0;
      word_char(c);
    endfunction

    function void take_end_of_line();
      logic [1:0] st;
      st = err_code;
      if (st == STAT_OK) begin
        if (escape_open) st = STAT_BACKSLASH;
        else if (in_word && (single_q || double_q)) st = STAT_QUOTE;
        else if (in_word || greater_open) close_token();
      end
      push(KIND_DONE, 8'd0, st);
      in_word      = 1'b0;
      single_q     = 1'b0;
      double_q     = 1'b0;
      escape_open  = 1'b0;
      greater_open = 1'b0;
      tokens_done  = '0;
      err_code     = STAT_OK;
    endfunction

    function void note_request(bit mode, logic [7:0] c);
      step_events.delete();
      if (mode == MODE_EOL) take_end_of_line();
      else if (err_code == STAT_OK) take_line_byte(c);
      if (step_events.size() != 0) step_events[step_events.size() - 1].last = 1'b1;
      foreach (step_events[i]) token_events.push_back(step_events[i]);
    endfunction

    task check_result(logic [1:0] kind, logic [23:0] data, logic last);
      token_event_t want;
      if (token_events.size() == 0) begin
        report($sformatf("unexpected result kind %0d data %h last %0d", kind, data, last));
        return;
      end
      want = token_events.pop_front();
      checked++;
      if (kind !== want.kind)
        report($sformatf("kind %0d, expected %0d", kind, want.kind));
      if (data[7:0] !== want.tok)
        report($sformatf("token byte %h, expected %h", data[7:0], want.tok));
      if (data[14:8] !== want.count)
        report($sformatf("token count %0d, expected %0d", data[14:8], want.count));
      if (data[16:15] !== want.status)
        report($sformatf("status %0d, expected %0d", data[16:15], want.status));
      if (data[23:17] !== 7'd0)
        report($sformatf("padding bits %h not zero", data[23:17]));
      if (last !== want.last)
        report($sformatf("last flag %0d, expected %0d", last, want.last));
      if (want.kind == KIND_DONE) begin
        lines_done++;
        status_seen[want.status]++;
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data   = 7'd0;

  token_scoreboard line_check;
  int          items_sent;
  int          burst_left;
  int          limits_used;
  logic [7:0]  rx_tick = 8'd0;
  logic [6:0]  limit_plan [8] = '{7'd3, 7'd127, 7'd1, 7'd0, 7'd64, 7'd2, 7'd17, 7'd127};

  quoted_word_tokenizer #(.MAX_TOKENS(TOKEN_CAP)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("quoted_word_tokenizer_test: FAIL");
    $finish;
  end

  // Receiver: check every taken result, stall on a rotating pattern.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      line_check.check_result(out_tuser, out_tdata, out_tlast);
    rx_tick <= rx_tick + 8'd1;
    case (rx_tick[7:6])
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= ($urandom_range(0, 1) == 0);
      2'd2: out_tready <= (rx_tick[1:0] == 2'd0);
      default: out_tready <= ($urandom_range(0, 4) != 0);
    endcase
  end

  task send_request(bit mode, logic [7:0] b);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    line_check.note_request(mode, b);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 3);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
  endtask

  task send_eol();
    send_request(MODE_EOL, 8'($urandom_range(0, 255)));
  endtask

  task send_text(string s);
    for (int i = 0; i < s.len(); i++) send_request(MODE_BYTE, s[i]);
  endtask

  // Hold the input until every result has drained, then write the limit.
  task write_limit(logic [6:0] value);
    in_tvalid <= 1'b0;
    while (line_check.token_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    line_check.token_limit = value;
    limits_used++;
  endtask

  function logic [7:0] plain_char();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return CH_A + 8'($urandom_range(0, 25));
  endfunction

  function logic [7:0] any_but(logic [7:0] a, logic [7:0] b);
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    return (c == a || c == b) ? CH_X : c;
  endfunction

  // Build a line from well-formed pieces with some noise mixed in.
  task send_random_line();
    logic [7:0] text[$];
    int pieces;
    int n;
    pieces = $urandom_range(0, 7);
    for (int k = 0; k < pieces; k++) begin
      if (text.size() != 0 && $urandom_range(0, 1) == 1)
        text.push_back(BLANKS[$urandom_range(0, 5)]);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: begin
          n = $urandom_range(1, 5);
          repeat (n) text.push_back(plain_char());
        end
        6: begin
          n = $urandom_range(1, 3);
          repeat (n) text.push_back(BLANKS[$urandom_range(0, 5)]);
        end
        7, 8: begin
          text.push_back(CH_SQ);
          n = $urandom_range(0, 4);
          repeat (n) text.push_back(any_but(CH_SQ, CH_SQ));
          text.push_back(CH_SQ);
        end
        9, 10: begin
          text.push_back(CH_DQ);
          n = $urandom_range(0, 4);
          repeat (n) begin
            if ($urandom_range(0, 3) == 0) begin
              text.push_back(CH_BSL);
              text.push_back(8'($urandom_range(0, 255)));
            end else begin
              text.push_back(any_but(CH_DQ, CH_BSL));
            end
          end
          text.push_back(CH_DQ);
        end
        11: begin
          text.push_back(CH_BSL);
          text.push_back(8'($urandom_range(0, 255)));
        end
        12: text.push_back(CH_LT);
        13: text.push_back(CH_GT);
        14: begin
          text.push_back(CH_GT);
          text.push_back(CH_GT);
        end
        15: begin
          if ($urandom_range(0, 1) == 0) begin
            text.push_back(CH_SQ);
            text.push_back(CH_SQ);
          end else begin
            text.push_back(CH_DQ);
            text.push_back(CH_DQ);
          end
        end
        16: begin
          n = $urandom_range(1, 3);
          repeat (n) text.push_back(($urandom_range(0, 1) == 0) ? CH_LT : CH_GT);
        end
        17: begin
          n = $urandom_range(1, 3);
          repeat (n) text.push_back(8'($urandom_range(0, 255)));
        end
        18: text.push_back(($urandom_range(0, 1) == 0) ? CH_SQ : CH_DQ);
        default: text.push_back(CH_BSL);
      endcase
    end
    foreach (text[i]) send_request(MODE_BYTE, text[i]);
    send_eol();
  endtask

  initial begin
    int start;
    int wait_left;
    line_check = new;
    burst_left = 4;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero and all-ones bytes in a word, then an empty quoted word
    send_request(MODE_BYTE, 8'h00);
    send_request(MODE_BYTE, 8'hFF);
    send_text(" ''");
    send_eol();
    // redirections glued to words, append form, open '>' at end of line
    send_text("a<>>b>");
    send_eol();
    send_text("\"x");
    send_eol();
    send_text("\\");
    send_eol();
    write_limit(7'd1);
    send_text("p q");
    send_eol();
    write_limit(7'd0);
    send_text("z");
    send_eol();

    foreach (limit_plan[p]) begin
      write_limit(limit_plan[p]);
      // run past the hard cap with a line of single-character tokens
      if (p == 1 || p == 4) begin
        repeat (TOKEN_CAP + 1) send_request(MODE_BYTE, CH_LT);
        send_eol();
      end
      start = items_sent;
      while (items_sent - start < 30) send_random_line();
    end

    in_tvalid <= 1'b0;
    wait_left = 20000;
    while (line_check.token_events.size() != 0 && wait_left > 0) begin
      @(posedge clk);
      wait_left--;
    end
    repeat (8) @(posedge clk);
    if (line_check.token_events.size() != 0)
      line_check.report($sformatf("%0d results never arrived",
                                  line_check.token_events.size()));

    $display("covered %0d requests in %0d lines, %0d results, %0d limit writes",
             items_sent, line_check.lines_done, line_check.checked, limits_used);
    $display("line endings: ok %0d, over limit %0d, open quote %0d, dangling escape %0d",
             line_check.status_seen[0], line_check.status_seen[1],
             line_check.status_seen[2], line_check.status_seen[3]);
    if (line_check.mismatches == 0)
      $display("quoted_word_tokenizer_test: PASS");
    else
      $display("quoted_word_tokenizer_test: FAIL");
    $finish;
  end

endmodule

// ===== quoted_word_tokenizer.f =====
rtl/qwt_pkg.sv
rtl/qwt_step.sv
rtl/quoted_word_tokenizer.sv
tb/sv/quoted_word_tokenizer_test.sv
